// ----- rtl/mfq_pkg.sv -----
// Shared types and constants of the four-level feedback scheduler.
package mfq_pkg;

  localparam int unsigned THREAD_W   = 6;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned SLICE_W    = 8;
  localparam int unsigned TOTAL_W    = 9;
  localparam int unsigned NUM_LEVELS = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LVL_ENTRIES = 2 ** THREAD_W;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL  = 2'd0;
  localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

  localparam logic [SLICE_W-1:0] SLICE_RESET [NUM_LEVELS] = '{8'd1, 8'd2, 8'd4, 8'd8};

  typedef enum logic [1:0] {
    CMD_ARRIVAL  = 2'd0,
    CMD_PREEMPT  = 2'd1,
    CMD_IO_DONE  = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [THREAD_W-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic                dispatched_valid;
    logic [THREAD_W-1:0] dispatched_thread;
    logic [SLICE_W-1:0]  slice_length;
    logic [LEVEL_W-1:0]  selected_level;
    logic [TOTAL_W-1:0]  queued_total;
    logic                push_dropped;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [THREAD_W-1:0] addr;
    logic [LEVEL_W-1:0]  data;
  } lvl_wr_t;

endpackage

// ----- rtl/mfq_level_mem.sv -----
// Level table: the current queue level of every thread, one synchronous read port.
module mfq_level_mem (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [mfq_pkg::THREAD_W-1:0] rd_addr_i,
  output logic [mfq_pkg::LEVEL_W-1:0]  rd_data_o,
  input  mfq_pkg::lvl_wr_t             wr_i
);
  import mfq_pkg::*;

  logic [LEVEL_W-1:0] mem_q [LVL_ENTRIES];
  logic [LEVEL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/mfq_slot_mem.sv -----
// Queue slot storage: all four FIFOs side by side, one write and one synchronous read port.
module mfq_slot_mem #(
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [mfq_pkg::THREAD_W-1:0] wr_data_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [mfq_pkg::THREAD_W-1:0] rd_data_o
);
  import mfq_pkg::*;

  logic [THREAD_W-1:0] mem_q [DEPTH];
  logic [THREAD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/multilevel_feedback_queue.sv -----
// An accepted command moves the state to execute; the result and its strobe are registered there.
// No new command is accepted while busy; the level table and slot memory reads at acceptance
// are followed by the write-back in the execute state.
// The next command is taken in the same cycle that the previous result is strobed.
// Reset clears queue heads, counts and the total, and loads slices 1, 2, 4 and 8;
// the level table and slot storage are not cleared, and no initialisation runs after reset.
module multilevel_feedback_queue #(
  parameter int unsigned MAX_THREADS = 64,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mfq_pkg::in_item_t             item_i,
  output logic                          done_o,
  output mfq_pkg::out_item_t            result_o,
  input  logic                          cfg_we_i,
  input  logic [mfq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mfq_pkg::SLICE_W-1:0]   cfg_data_i
);
  import mfq_pkg::*;

  localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW    = CW + 1;
  localparam int unsigned SLOTS = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned FAW   = $clog2(SLOTS);

  state_e              state_q, state_d;
  logic [QW-1:0]       head_q  [NUM_LEVELS];
  logic [QW-1:0]       head_d  [NUM_LEVELS];
  logic [CW-1:0]       count_q [NUM_LEVELS];
  logic [CW-1:0]       count_d [NUM_LEVELS];
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [SLICE_W-1:0]  slice_q [NUM_LEVELS];
  logic                done_q, done_d;
  out_item_t           out_q, out_d;

  // Transaction held for the execute cycle.
  cmd_e                cmd_q;
  logic [THREAD_W-1:0] tid_q;
  logic [LEVEL_W-1:0]  lvl_q;
  logic                hit_q;

  logic                accept;
  logic [LEVEL_W-1:0]  pick_lvl;
  logic                pick_hit;
  logic [FAW-1:0]      rd_addr;
  logic [LEVEL_W-1:0]  cur_lvl;
  logic [THREAD_W-1:0] slot_rdata;
  logic [LEVEL_W-1:0]  target;
  logic [SW-1:0]       slot_sum;
  logic [QW-1:0]       slot;
  logic                slot_we;
  logic [FAW-1:0]      slot_waddr;
  lvl_wr_t             lvl_wr;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_EXEC);

  // Highest non-empty level; counts are stable from acceptance through execute.
  always_comb begin
    pick_lvl = TOP_LEVEL;
    pick_hit = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        pick_lvl = LEVEL_W'(l);
        pick_hit = 1'b1;
      end
    end
  end

  assign rd_addr = FAW'(pick_lvl) * FAW'(QUEUE_DEPTH) + FAW'(head_q[pick_lvl]);

  mfq_level_mem u_level_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (item_i.thread_id),
    .rd_data_o (cur_lvl),
    .wr_i      (lvl_wr)
  );

  mfq_slot_mem #(
    .DEPTH (SLOTS)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (slot_we),
    .wr_addr_i (slot_waddr),
    .wr_data_i (tid_q),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (slot_rdata)
  );

  always_comb begin
    unique case (cmd_q)
      CMD_ARRIVAL: target = TOP_LEVEL;
      CMD_PREEMPT: target = (cur_lvl == LAST_LEVEL) ? LAST_LEVEL : cur_lvl + 1'b1;
      CMD_IO_DONE: target = cur_lvl;
      default:     target = cur_lvl;
    endcase
    slot_sum = SW'(head_q[target]) + SW'(count_q[target]);
    if (slot_sum >= SW'(QUEUE_DEPTH)) begin
      slot = QW'(slot_sum - SW'(QUEUE_DEPTH));
    end else begin
      slot = QW'(slot_sum);
    end
  end

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    total_d    = total_q;
    done_d     = 1'b0;
    out_d      = '0;
    slot_we    = 1'b0;
    slot_waddr = FAW'(target) * FAW'(QUEUE_DEPTH) + FAW'(slot);
    lvl_wr     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if (cmd_q == CMD_DISPATCH) begin
          if (hit_q) begin
            out_d.dispatched_valid  = 1'b1;
            out_d.dispatched_thread = slot_rdata;
            out_d.slice_length      = slice_q[lvl_q];
            out_d.selected_level    = lvl_q;
            head_d[lvl_q]  = (head_q[lvl_q] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : head_q[lvl_q] + 1'b1;
            count_d[lvl_q] = count_q[lvl_q] - 1'b1;
            total_d        = total_q - 1'b1;
          end
        end else if (32'(tid_q) >= MAX_THREADS) begin
          out_d.push_dropped = 1'b1;
        end else if (count_q[target] == CW'(QUEUE_DEPTH)) begin
          out_d.push_dropped = 1'b1;
        end else begin
          slot_we         = 1'b1;
          lvl_wr.en       = 1'b1;
          lvl_wr.addr     = tid_q;
          lvl_wr.data     = target;
          count_d[target] = count_q[target] + 1'b1;
          total_d         = total_q + 1'b1;
        end
        out_d.queued_total = total_d;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      total_q <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
        slice_q[l] <= SLICE_RESET[l];
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      total_q <= total_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        slice_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      cmd_q <= item_i.command;
      tid_q <= item_i.thread_id;
      lvl_q <= pick_lvl;
      hit_q <= pick_hit;
    end
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

// ----- rtl/mfq_checker.sv -----
// Port-level checks of the scheduler's command timing and result fields, bound to the top level.
module mfq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input mfq_pkg::out_item_t result_o
);
  import mfq_pkg::*;

  // An accepted transaction keeps the block busy for exactly one cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy lasted more than one cycle");

  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing two cycles after acceptance");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  // A result that carries no thread carries no slice, thread or level either.
  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.dispatched_valid) |->
      (result_o.slice_length == '0 && result_o.dispatched_thread == '0 &&
       result_o.selected_level == '0))
    else $error("result without a thread has nonzero fields");

endmodule

bind multilevel_feedback_queue mfq_checker u_mfq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
